>>> sv/alis_pkg.sv
// Shared types and constants for the array list block.
// Used by alis_ctrl, the top level and the checker; depends on nothing.
`default_nettype none

package alis_pkg;

  localparam int unsigned DEPTH   = 1024;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 56;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOCATE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [KEY_W-1:0]  wdata;
    logic              re;
    logic [AW-1:0]     raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> sv/alis_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
// Generic; no package dependency.
`default_nettype none

module alis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/alis_ctrl.sv
// Command sequencer for the array list: decodes each beat, walks the key
// memory for remove and locate, and holds the result register. Uses alis_pkg.
`default_nettype none

module alis_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire alis_pkg::op_t                  in_op,
  input  wire logic [alis_pkg::KEY_W-1:0]     in_key,
  input  wire logic [alis_pkg::POS_W-1:0]     in_pos,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output alis_pkg::status_t                   out_status,
  output logic      [alis_pkg::KEY_W-1:0]     out_key,
  output logic      [alis_pkg::POS_W-1:0]     out_found,
  output logic      [alis_pkg::POS_W-1:0]     out_count,
  output alis_pkg::mem_req_t                  mem_req,
  input  wire logic [alis_pkg::KEY_W-1:0]     mem_rdata
);

  import alis_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RFIRST = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_LOC    = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     len_r, len_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [KEY_W-1:0]  res_key_r, res_key_nxt;
  logic [CW-1:0]     res_found_r, res_found_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [KEY_W-1:0]  out_key_r, out_key_nxt;
  logic [CW-1:0]     out_found_r, out_found_nxt;
  logic [CW-1:0]     out_count_r, out_count_nxt;

  logic [CW-1:0]     ptr_inc;
  logic [CW-1:0]     ptr_dec;
  logic [CW-1:0]     pos_c;
  logic [CW-1:0]     pos_dec;

  assign ptr_inc = ptr_r + 1'b1;
  assign ptr_dec = ptr_r - 1'b1;
  assign pos_c   = CW'(in_pos);
  assign pos_dec = pos_c - 1'b1;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    ptr_nxt        = ptr_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    mem_req        = '0;

    // drop the result beat once taken
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt        = in_key;
          res_status_nxt = ST_OK;
          res_key_nxt    = '0;
          res_found_nxt  = '0;
          state_nxt      = S_DONE;
          unique case (in_op)
            OP_INSERT: begin
              if (len_r >= CW'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = len_r[AW-1:0];
                mem_req.wdata = in_key;
                len_nxt       = len_r + 1'b1;
              end
            end
            OP_REMOVE: begin
              if (pos_c == '0 || pos_c > len_r) begin
                res_status_nxt = ST_BAD_POS;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = pos_dec[AW-1:0];
                ptr_nxt       = pos_dec;
                state_nxt     = S_RFIRST;
              end
            end
            OP_LOCATE: begin
              if (len_r == '0) begin
                res_status_nxt = ST_NOT_FOUND;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = '0;
                ptr_nxt       = '0;
                state_nxt     = S_LOC;
              end
            end
            OP_CLEAR: begin
              len_nxt = '0;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_RFIRST: begin
        res_key_nxt = mem_rdata;
        if (ptr_inc < len_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ptr_inc[AW-1:0];
          ptr_nxt       = ptr_inc;
          state_nxt     = S_SHIFT;
        end else begin
          len_nxt   = len_r - 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_SHIFT: begin
        // write behind, read ahead: addresses never meet
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_dec[AW-1:0];
        mem_req.wdata = mem_rdata;
        if (ptr_inc < len_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ptr_inc[AW-1:0];
          ptr_nxt       = ptr_inc;
        end else begin
          len_nxt   = len_r - 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_LOC: begin
        if (mem_rdata == key_r) begin
          res_found_nxt = ptr_inc;
          state_nxt     = S_DONE;
        end else if (ptr_inc < len_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ptr_inc[AW-1:0];
          ptr_nxt       = ptr_inc;
        end else begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end
      end

      S_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = res_key_r;
          out_found_nxt  = res_found_r;
          out_count_nxt  = len_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_key    = out_key_r;
  assign out_found  = POS_W'(out_found_r);
  assign out_count  = POS_W'(out_count_r);

endmodule

`default_nettype wire

>>> sv/array_list_insert_remove_search.sv
// Array list top level: stream ports, command sequencer and key memory.
// Depends on alis_pkg, alis_ctrl and alis_ram.
//
// Usage: each input beat carries one command (in_tuser = opcode: insert,
// remove, locate, clear) with a key and a one-based position in in_tdata.
// Every command yields exactly one result beat: status in out_tuser, and
// the removed key, the located position and the count after the command
// in out_tdata.
// Insert, clear and rejected commands go straight to the result stage.
// The single key memory, one read and one write per cycle, paces the
// walks: remove reads the removed key, then walks the tail one entry per
// cycle; locate compares one entry per cycle until it finds the key or
// reaches the end of the list. One command is processed at a time;
// in_tready is high only while the sequencer is idle.
// A finished result sits in an output register, so the next command is
// taken while a result waits; a stalled out_tready holds the result beat
// and, once the next command is done, holds in_tready low.
// Reset clears the count and the output valid; the key memory is not
// cleared and needs no clearing pass, as only written entries are read.
`default_nettype none

module array_list_insert_remove_search (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [alis_pkg::IN_DATA_W-1:0]     in_tdata,   // key[31:0], position[42:32]
  input  wire logic [1:0]                         in_tuser,   // opcode[1:0]
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [alis_pkg::OUT_DATA_W-1:0]    out_tdata,  // key_out[31:0],
                                                              // found_position[42:32],
                                                              // entry_count[53:43]
  output logic      [1:0]                         out_tuser   // status[1:0]
);

  import alis_pkg::*;

  mem_req_t          mem_req;
  logic [KEY_W-1:0]  mem_rdata;
  status_t           out_status;
  logic [KEY_W-1:0]  out_key;
  logic [POS_W-1:0]  out_found;
  logic [POS_W-1:0]  out_count;

  alis_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (op_t'(in_tuser)),
    .in_key     (in_tdata[KEY_W-1:0]),
    .in_pos     (in_tdata[KEY_W+POS_W-1:KEY_W]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_status),
    .out_key    (out_key),
    .out_found  (out_found),
    .out_count  (out_count),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata)
  );

  alis_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  assign out_tdata = {{(OUT_DATA_W - KEY_W - 2*POS_W){1'b0}}, out_count, out_found, out_key};
  assign out_tuser = out_status;

endmodule

`default_nettype wire

>>> sv/alis_checker.sv
// Port-level checks for the array list top level, attached with bind.
// Depends on alis_pkg and array_list_insert_remove_search.
`default_nettype none

module alis_checker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  input  wire logic                               in_tready,
  input  wire logic [alis_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic [1:0]                         in_tuser,
  input  wire logic                               out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic [alis_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire logic [1:0]                         out_tuser
);

  import alis_pkg::*;

  logic [KEY_W-1:0] chk_key;
  logic [POS_W-1:0] chk_found;
  logic [POS_W-1:0] chk_count;
  logic             chk_in_beat;

  assign chk_key     = out_tdata[KEY_W-1:0];
  assign chk_found   = out_tdata[KEY_W+POS_W-1:KEY_W];
  assign chk_count   = out_tdata[KEY_W+2*POS_W-1:KEY_W+POS_W];
  assign chk_in_beat = in_tvalid && in_tready && (in_tdata != '1 || in_tuser != '1);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> chk_count == POS_W'(DEPTH))
    else $error("full reported below capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_BAD_POS || out_tuser == ST_NOT_FOUND)
    |-> chk_key == '0 && chk_found == '0)
    else $error("failed command carries payload");

  // an input beat is never taken while the sequencer still works
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    chk_in_beat && in_tuser != OP_CLEAR |=> !in_tready)
    else $error("second command taken too early");

endmodule

bind array_list_insert_remove_search alis_checker u_alis_checker (.*);

`default_nettype wire
